// ===== rtl/ddpm_pkg.sv =====
// Package: widths, codes, reset values, command/status types and helpers for the mixer.
`default_nettype none
package ddpm_pkg;

  localparam int unsigned PWM_BITS_DEF = 10;
  localparam int unsigned CNT_W        = 10;
  localparam int unsigned SPEED_W      = 16;
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [REQ_W-1:0] REQ_CMD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MS   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CTRL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_LINEAR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ANGULAR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_SEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT      = 3'd5;

  localparam logic [14:0] MAX_LINEAR_RST  = 15'd2048;
  localparam logic [14:0] MAX_ANGULAR_RST = 15'd8192;
  localparam logic [15:0] HALF_SEP_RST    = 16'd3277;
  localparam logic [15:0] DUTY_SCALE_RST  = 16'd4096;
  localparam logic [15:0] TIMEOUT_RST     = 16'd500;
  localparam logic [1:0]  INVERT_RST      = 2'd0;

  typedef struct packed {
    logic load;
    logic mul_ws;
    logic mix;
    logic mul_scale;
    logic store;
    logic ms_inc;
    logic wdog;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  // symmetric clamp of a signed speed to +/- lim
  function automatic logic signed [15:0] clamp_lim(input logic signed [15:0] x,
                                                   input logic [14:0] lim);
    logic signed [16:0] xe;
    logic signed [16:0] le;
    logic signed [16:0] nle;
    xe  = {x[15], x};
    le  = $signed({2'b00, lim});
    nle = -le;
    if (xe > le) return le[15:0];
    else if (xe < nle) return nle[15:0];
    else return x;
  endfunction

  // saturate to the symmetric Q1.15 duty range
  function automatic logic signed [15:0] sat_duty(input logic signed [24:0] d);
    if (d > 25'sd32767) return 16'sd32767;
    else if (d < -25'sd32767) return -16'sd32767;
    else return d[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ddpm_in_if.sv =====
// Interface: request channel (velocity command, ms tick, control tick).
`default_nettype none
interface ddpm_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [ddpm_pkg::REQ_W-1:0]             req_type;
  logic signed [ddpm_pkg::SPEED_W-1:0]    linear_speed;
  logic signed [ddpm_pkg::SPEED_W-1:0]    angular_speed;

  modport source (output valid, req_type, linear_speed, angular_speed, input ready);
  modport sink   (input valid, req_type, linear_speed, angular_speed, output ready);
endinterface
`default_nettype wire

// ===== rtl/ddpm_out_if.sv =====
// Interface: PWM compare count result channel.
`default_nettype none
interface ddpm_out_if;
  logic                         valid;
  logic                         ready;
  logic [ddpm_pkg::CNT_W-1:0]   left_fwd;
  logic [ddpm_pkg::CNT_W-1:0]   left_rev;
  logic [ddpm_pkg::CNT_W-1:0]   right_fwd;
  logic [ddpm_pkg::CNT_W-1:0]   right_rev;

  modport source (output valid, left_fwd, left_rev, right_fwd, right_rev, input ready);
  modport sink   (input valid, left_fwd, left_rev, right_fwd, right_rev, output ready);
endinterface
`default_nettype wire

// ===== rtl/ddpm_cfg_if.sv =====
// Interface: configuration register write channel.
`default_nettype none
interface ddpm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ddpm_pkg::CFG_IDX_W-1:0]    index;
  logic [ddpm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/diff_drive_pwm_mixer_unit.sv =====
// Top level: differential-drive mixer with watchdog and sign-split PWM counts.
//
//  channel  role    fields
//  in_ch    sink    req_type, linear_speed, angular_speed
//  out_ch   source  left_fwd, left_rev, right_fwd, right_rev
//  cfg      sink    index, data (always ready)
//
// One word in flight; in_ch is ready only while the controller is idle.
// Velocity command steps: clamp/multiply, mix, scale multiply, store.
// Ms tick: elapsed counter increment. Control tick: watchdog and sign split, then
// output load, which waits while out_ch stalls a previous result still held in the output register.
// Synchronous reset restores register defaults and clears duties and counter.
`default_nettype none
module diff_drive_pwm_mixer_unit #(
  parameter int unsigned PWM_BITS = ddpm_pkg::PWM_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ddpm_in_if.sink     in_ch,
  ddpm_out_if.source  out_ch,
  ddpm_cfg_if.sink    cfg
);

  ddpm_pkg::ctl_cmd_t cmd;
  ddpm_pkg::dp_stat_t stat;
  logic               in_ready;

  assign in_ch.ready = in_ready;
  assign cfg.ready   = 1'b1;

  ddpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_req   (in_ch.req_type),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ddpm_dp #(
    .PWM_BITS (PWM_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .linear_speed  (in_ch.linear_speed),
    .angular_speed (in_ch.angular_speed),
    .cfg_we        (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .left_fwd      (out_ch.left_fwd),
    .left_rev      (out_ch.left_rev),
    .right_fwd     (out_ch.right_fwd),
    .right_rev     (out_ch.right_rev)
  );

endmodule
`default_nettype wire

// ===== rtl/ddpm_ctrl.sv =====
// Controller: sequences command, ms tick and control tick words through the datapath.
`default_nettype none
module ddpm_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [ddpm_pkg::REQ_W-1:0]  in_req,
  output logic                             in_ready,
  input  wire ddpm_pkg::dp_stat_t          stat,
  output ddpm_pkg::ctl_cmd_t               cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD_MUL,
    S_CMD_MIX,
    S_CMD_SCALE,
    S_CMD_STORE,
    S_MS,
    S_CTL_SIGN,
    S_CTL_OUT
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    cmd.mul_ws    = (state == S_CMD_MUL);
    cmd.mix       = (state == S_CMD_MIX);
    cmd.mul_scale = (state == S_CMD_SCALE);
    cmd.store     = (state == S_CMD_STORE);
    cmd.ms_inc    = (state == S_MS);
    cmd.wdog      = (state == S_CTL_SIGN);
    cmd.out_load  = (state == S_CTL_OUT) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority if (in_req == ddpm_pkg::REQ_CMD) state <= S_CMD_MUL;
            else if (in_req == ddpm_pkg::REQ_MS) state <= S_MS;
            else if (in_req == ddpm_pkg::REQ_CTRL) state <= S_CTL_SIGN;
            else state <= S_IDLE;
          end
        end
        S_CMD_MUL:   state <= S_CMD_MIX;
        S_CMD_MIX:   state <= S_CMD_SCALE;
        S_CMD_SCALE: state <= S_CMD_STORE;
        S_CMD_STORE: state <= S_IDLE;
        S_MS:        state <= S_IDLE;
        S_CTL_SIGN:  state <= S_CTL_OUT;
        S_CTL_OUT: begin
          if (!stat.out_busy) state <= S_IDLE;
        end
        default:     state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ddpm_dp.sv =====
// Datapath: config registers, mixing and scaling arithmetic, duty state, watchdog, PWM counts.
`default_nettype none
module ddpm_dp #(
  parameter int unsigned PWM_BITS = ddpm_pkg::PWM_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire ddpm_pkg::ctl_cmd_t                   cmd,
  output ddpm_pkg::dp_stat_t                        stat,
  input  wire logic signed [ddpm_pkg::SPEED_W-1:0]  linear_speed,
  input  wire logic signed [ddpm_pkg::SPEED_W-1:0]  angular_speed,
  input  wire logic                                 cfg_we,
  input  wire logic [ddpm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ddpm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 out_ready,
  output logic                                      out_valid,
  output logic [ddpm_pkg::CNT_W-1:0]                left_fwd,
  output logic [ddpm_pkg::CNT_W-1:0]                left_rev,
  output logic [ddpm_pkg::CNT_W-1:0]                right_fwd,
  output logic [ddpm_pkg::CNT_W-1:0]                right_rev
);

  localparam int unsigned PROD_W = 15 + PWM_BITS;
  localparam logic [PWM_BITS-1:0] PMAX = '1;
  localparam int unsigned CNT_W_L = ddpm_pkg::CNT_W;

  // configuration
  logic [14:0] max_linear;
  logic [14:0] max_angular;
  logic [15:0] half_separation;
  logic [15:0] duty_scale;
  logic [15:0] timeout_ms;
  logic [1:0]  invert_mask;

  // state
  logic signed [15:0] left_duty;
  logic signed [15:0] right_duty;
  logic [15:0]        elapsed_ms;

  // pipeline registers
  logic signed [15:0] lin_q;
  logic signed [15:0] ang_q;
  logic signed [15:0] v_q;
  logic signed [32:0] ws_prod;
  logic signed [16:0] left_w;
  logic signed [16:0] right_w;
  logic signed [33:0] left_p;
  logic signed [33:0] right_p;
  logic               l_neg;
  logic               r_neg;
  logic [14:0]        l_mag;
  logic [14:0]        r_mag;

  logic signed [16:0] ws;
  logic signed [24:0] left_d;
  logic signed [24:0] right_d;
  logic               expired;
  logic signed [15:0] ld;
  logic signed [15:0] rd;
  logic signed [15:0] ld_abs;
  logic signed [15:0] rd_abs;
  logic [PROD_W-1:0]  l_prod;
  logic [PROD_W-1:0]  r_prod;
  logic [CNT_W_L-1:0] l_cnt;
  logic [CNT_W_L-1:0] r_cnt;

  assign ws      = ws_prod[32:16];
  assign left_d  = left_p[33:9];
  assign right_d = right_p[33:9];
  assign expired = elapsed_ms > timeout_ms;
  assign ld      = expired ? 16'sd0 : left_duty;
  assign rd      = expired ? 16'sd0 : right_duty;
  assign ld_abs  = ld[15] ? -ld : ld;
  assign rd_abs  = rd[15] ? -rd : rd;
  assign l_prod  = PROD_W'(l_mag) * PROD_W'(PMAX);
  assign r_prod  = PROD_W'(r_mag) * PROD_W'(PMAX);
  assign l_cnt   = CNT_W_L'(l_prod >> 15);
  assign r_cnt   = CNT_W_L'(r_prod >> 15);

  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_linear      <= ddpm_pkg::MAX_LINEAR_RST;
      max_angular     <= ddpm_pkg::MAX_ANGULAR_RST;
      half_separation <= ddpm_pkg::HALF_SEP_RST;
      duty_scale      <= ddpm_pkg::DUTY_SCALE_RST;
      timeout_ms      <= ddpm_pkg::TIMEOUT_RST;
      invert_mask     <= ddpm_pkg::INVERT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ddpm_pkg::REG_MAX_LINEAR:  max_linear      <= cfg_data[14:0];
        ddpm_pkg::REG_MAX_ANGULAR: max_angular     <= cfg_data[14:0];
        ddpm_pkg::REG_HALF_SEP:    half_separation <= cfg_data;
        ddpm_pkg::REG_DUTY_SCALE:  duty_scale      <= cfg_data;
        ddpm_pkg::REG_TIMEOUT:     timeout_ms      <= cfg_data;
        ddpm_pkg::REG_INVERT:      invert_mask     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lin_q <= linear_speed;
      ang_q <= angular_speed;
    end
    if (cmd.mul_ws) begin
      v_q     <= ddpm_pkg::clamp_lim(lin_q, max_linear);
      ws_prod <= 33'(ddpm_pkg::clamp_lim(ang_q, max_angular)) * $signed({1'b0, half_separation});
    end
    if (cmd.mix) begin
      left_w  <= {v_q[15], v_q} - ws;
      right_w <= {v_q[15], v_q} + ws;
    end
    if (cmd.mul_scale) begin
      left_p  <= 34'(left_w) * $signed({1'b0, duty_scale});
      right_p <= 34'(right_w) * $signed({1'b0, duty_scale});
    end
    if (cmd.wdog) begin
      l_neg <= invert_mask[0] ? (!ld[15] && (ld != 16'sd0)) : ld[15];
      r_neg <= invert_mask[1] ? (!rd[15] && (rd != 16'sd0)) : rd[15];
      l_mag <= ld_abs[14:0];
      r_mag <= rd_abs[14:0];
    end
    if (cmd.out_load) begin
      left_fwd  <= l_neg ? '0 : l_cnt;
      left_rev  <= l_neg ? l_cnt : '0;
      right_fwd <= r_neg ? '0 : r_cnt;
      right_rev <= r_neg ? r_cnt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_duty  <= '0;
      right_duty <= '0;
      elapsed_ms <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.store) begin
        left_duty  <= ddpm_pkg::sat_duty(left_d);
        right_duty <= ddpm_pkg::sat_duty(right_d);
        elapsed_ms <= '0;
      end else if (cmd.wdog && expired) begin
        left_duty  <= '0;
        right_duty <= '0;
      end else if (cmd.ms_inc && (elapsed_ms != 16'hFFFF)) begin
        elapsed_ms <= elapsed_ms + 16'd1;
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_ms_count: assert property (@(posedge clk) disable iff (rst)
    cmd.ms_inc && (elapsed_ms != 16'hFFFF) |=> elapsed_ms == 16'($past(elapsed_ms) + 16'd1))
    else $error("elapsed counter did not advance on ms tick");

  a_wdog_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.wdog && expired |=> (left_duty == 16'sd0) && (right_duty == 16'sd0))
    else $error("watchdog expiry left nonzero duty");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("result register loaded while previous word pending");

endmodule
`default_nettype wire
